// ===== src/rpsg_pkg.sv =====
// rpsg_pkg: shared types and constants for the ramped pwm setpoint generator
// sequencer state type, configuration register indexes and reset values
// no dependencies
package rpsg_pkg;

  localparam int CfgIndexW = 3;

  localparam logic [CfgIndexW-1:0] CFG_MAX_POWER     = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_MIN_POWER     = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_MAX_PWM       = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_MIN_PWM       = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_RAMP_DURATION = 3'd4;

  localparam logic [15:0] MAX_POWER_RESET     = 16'd1000;
  localparam logic [15:0] MIN_POWER_RESET     = 16'd0;
  localparam logic [15:0] MAX_PWM_RESET       = 16'd1000;
  localparam logic [15:0] MIN_PWM_RESET       = 16'd0;
  localparam logic [31:0] RAMP_DURATION_RESET = 32'd5000;

  localparam logic KIND_SET_SPEED = 1'b0;
  localparam logic KIND_TICK      = 1'b1;

  // which division the shared divider is working on
  localparam logic PHASE_RAMP = 1'b0;
  localparam logic PHASE_MAP  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_STEP,
    S_MAP,
    S_FIN
  } state_t;

endpackage

// ===== src/rpsg_div.sv =====
// rpsg_div: 32 by 32 bit unsigned restoring divider, one quotient bit a cycle
// a zero divisor yields an all-ones quotient
// no dependencies
module rpsg_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient
);

  logic [32:0] rem;
  logic [31:0] dvs;
  logic [4:0]  cnt;
  logic [32:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem[31:0], quotient[31]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient shifts in from the bottom as the dividend shifts out of the top
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
      quotient <= {quotient[30:0], fits};
    end
  end

endmodule

// ===== src/ramped_pwm_setpoint_generator_core.sv =====
// ramped_pwm_setpoint_generator_core: slew-rate limited power setpoint with pwm mapping
// depends on rpsg_pkg and rpsg_div
//
// Input stream (s_*): one transfer per item. s_tuser is the kind: set-speed or tick.
// A set-speed item clamps requested_power and stores it as the target. A tick item
// carries the millisecond time; the present power moves towards the target by
// max_power*period/ramp_duration and is then mapped to a pwm compare value.
// Output stream (m_*): exactly one result transfer per input item, carrying the
// current pwm value, the ramped power and a flag for a changed pwm value.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 max_power,
// 1 min_power, 2 max_pwm, 3 min_pwm, 4 ramp_duration); write only while idle.
// Sequence: a set-speed item or a tick with no ramp pending goes from idle straight to
// the result state. A ramping tick makes two passes through the shared divider (ramp
// step, then pwm mapping), each after a pass through the shared multiplier; with equal
// power limits the mapping pass is skipped. One item is in work at a time.
// s_tready is high only while the sequencer is idle; it may accept the next item
// while a finished result still waits in the output register.
// A stalled receiver holds the result; the block waits before delivering the next.
// Reset (rst, synchronous) restores the register defaults and clears the control state.
module ramped_pwm_setpoint_generator_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [47:0]                      s_tdata,   // requested_power[15:0], now_ms[47:16]
  input  logic                             s_tuser,   // kind
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [31:0]                      m_tdata,   // pwm_value[15:0], ramped_power[31:16]
  output logic                             m_tuser,   // pwm_written
  input  logic                             cfg_we,
  input  logic [rpsg_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data
);

  import rpsg_pkg::*;

  logic [15:0] max_power, min_power, max_pwm, min_pwm;
  logic [31:0] ramp_duration;

  logic [15:0] target_power, present_power, last_pwm;
  logic [31:0] last_tick, period, prod;
  logic        phase, written;

  state_t state, state_next;
  logic   div_start, div_busy, div_done;
  logic [31:0] div_quo;

  logic        in_xfer, out_free;
  logic [15:0] req, req_hi, req_clamped;
  logic [31:0] now_ms, period_now;

  logic [15:0] diff_mag, span_mag;
  logic        diff_neg, span_neg, span_zero;
  logic [15:0] mul_a;
  logic [31:0] mul_b;
  logic [47:0] mul_out;

  logic [15:0] step;
  logic [16:0] sum_up;
  logic [15:0] ramp_new;
  logic [15:0] q_low, pwm_calc;

  assign req        = s_tdata[15:0];
  assign now_ms     = s_tdata[47:16];
  assign in_xfer    = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign period_now = now_ms - last_tick;

  // max clamp first, then min clamp, so crossed limits give min_power
  assign req_hi      = (req >= max_power) ? max_power : req;
  assign req_clamped = (req_hi <= min_power) ? min_power : req_hi;

  // magnitudes and signs of the pwm span and the power span
  assign diff_neg  = max_pwm < min_pwm;
  assign diff_mag  = diff_neg ? (min_pwm - max_pwm) : (max_pwm - min_pwm);
  assign span_neg  = max_power < min_power;
  assign span_mag  = span_neg ? (min_power - max_power) : (max_power - min_power);
  assign span_zero = max_power == min_power;

  // shared multiplier, registered into prod
  assign mul_a   = (phase == PHASE_MAP) ? present_power : max_power;
  assign mul_b   = (phase == PHASE_MAP) ? {16'd0, diff_mag} : period;
  assign mul_out = {32'd0, mul_a} * {16'd0, mul_b};

  rpsg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  ((phase == PHASE_MAP) ? {16'd0, span_mag} : ramp_duration),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ramp step, never past the target, including wrap below zero
  assign step   = div_quo[15:0];
  assign sum_up = {1'b0, present_power} + {1'b0, step};
  always_comb begin
    if (target_power > present_power) begin
      ramp_new = (sum_up >= {1'b0, target_power}) ? target_power : sum_up[15:0];
    end else begin
      if (step >= present_power || (present_power - step) <= target_power) begin
        ramp_new = target_power;
      end else begin
        ramp_new = present_power - step;
      end
    end
  end

  // quotient truncates toward zero: negate the magnitude when the signs differ
  assign q_low    = (diff_neg ^ span_neg) ? (16'd0 - div_quo[15:0]) : div_quo[15:0];
  assign pwm_calc = span_zero ? min_pwm : (q_low + min_pwm);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == KIND_TICK && present_power != target_power) begin
            state_next = S_MUL;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_MUL:    state_next = S_DIV_GO;
      S_DIV_GO: begin
        div_start  = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = (phase == PHASE_MAP) ? S_MAP : S_STEP;
        end
      end
      S_STEP:   state_next = span_zero ? S_MAP : S_MUL;
      S_MAP:    state_next = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_power     <= MAX_POWER_RESET;
      min_power     <= MIN_POWER_RESET;
      max_pwm       <= MAX_PWM_RESET;
      min_pwm       <= MIN_PWM_RESET;
      ramp_duration <= RAMP_DURATION_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_POWER:     max_power     <= cfg_data[15:0];
        CFG_MIN_POWER:     min_power     <= cfg_data[15:0];
        CFG_MAX_PWM:       max_pwm       <= cfg_data[15:0];
        CFG_MIN_PWM:       min_pwm       <= cfg_data[15:0];
        CFG_RAMP_DURATION: ramp_duration <= cfg_data;
        default: ;
      endcase
    end
  end

  // ramp state
  always_ff @(posedge clk) begin
    if (rst) begin
      target_power  <= '0;
      present_power <= '0;
      last_tick     <= '0;
      last_pwm      <= '0;
      written       <= 1'b0;
      phase         <= PHASE_RAMP;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            written <= 1'b0;
            phase   <= PHASE_RAMP;
            if (s_tuser == KIND_SET_SPEED) begin
              if (req != target_power) begin
                target_power <= req_clamped;
              end
            end else if (period_now != 32'd0) begin
              last_tick <= now_ms;
            end
          end
        end
        S_STEP: begin
          present_power <= ramp_new;
          phase         <= PHASE_MAP;
        end
        S_MAP: begin
          if (pwm_calc != last_pwm) begin
            last_pwm <= pwm_calc;
            written  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_xfer) begin
      period <= period_now;
    end
    if (state == S_MUL) begin
      prod <= mul_out[31:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      m_tdata <= {present_power, last_pwm};
      m_tuser <= written;
    end
  end

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=>
      (m_tvalid && m_tdata[31:16] == present_power && m_tdata[15:0] == last_pwm))
    else $error("result does not match ramp state");

  a_ramp_up_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP && present_power < target_power) |=>
      (present_power <= $past(target_power) && present_power >= $past(present_power)))
    else $error("upward ramp step overshoots");

  a_ramp_down_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP && present_power > target_power) |=>
      (present_power >= $past(target_power) && present_power <= $past(present_power)))
    else $error("downward ramp step overshoots");

endmodule

// ===== verif/tb_ramped_pwm_setpoint_generator_core.sv =====
// tb_ramped_pwm_setpoint_generator_core: self-checking bench for the ramped pwm setpoint core
// predicts target, ramp step and pwm mapping per item and checks every result transfer
// depends on rpsg_pkg and ramped_pwm_setpoint_generator_core
module tb_ramped_pwm_setpoint_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rpsg_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int ITEMS_PER_PHASE = 190;

  typedef struct packed {
    logic        written;
    logic [15:0] pwm;
    logic [15:0] power;
  } pwm_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [47:0]          s_tdata = '0;   // requested_power[15:0], now_ms[47:16]
  logic                 s_tuser = 1'b0; // kind
  logic                 m_tvalid;
  logic                 m_tready = 1'b1;
  logic [31:0]          m_tdata;        // pwm_value[15:0], ramped_power[31:16]
  logic                 m_tuser;        // pwm_written
  logic                 cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = CFG_MAX_POWER;
  logic [31:0]          cfg_data = '0;

  // predicted registers and state
  logic [15:0] cfg_max_power, cfg_min_power, cfg_max_pwm, cfg_min_pwm;
  logic [31:0] cfg_ramp_ms;
  logic [15:0] target_power, present_power, last_pwm;
  logic [31:0] last_tick;

  pwm_result_t expected_pwm_q[$];

  int  err_count = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_updates = 0;
  int  n_settings = 0;
  int  idle_cycles = 0;
  int  rx_hold_req = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  logic [31:0] clock_ms = '0;

  ramped_pwm_setpoint_generator_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] power_to_pwm(input logic [15:0] p);
    longint span, num, q;
    span = longint'(cfg_max_power) - longint'(cfg_min_power);
    if (span == 0) return cfg_min_pwm;
    num = longint'(p) * (longint'(cfg_max_pwm) - longint'(cfg_min_pwm));
    q = num / span;   // truncates toward zero
    return 16'(q + longint'(cfg_min_pwm));
  endfunction

  function automatic pwm_result_t advance_setpoint(input logic kind, input logic [15:0] req,
                                                   input logic [31:0] now);
    pwm_result_t res;
    logic [31:0] period, prod, quo;
    logic [15:0] step, pwm, req_c;
    logic [16:0] up;
    res.written = 1'b0;
    if (kind == KIND_SET_SPEED) begin
      if (req != target_power) begin
        req_c = req;
        if (req_c >= cfg_max_power) req_c = cfg_max_power;
        if (req_c <= cfg_min_power) req_c = cfg_min_power;
        target_power = req_c;
      end
    end else begin
      period = now - last_tick;
      if (present_power != target_power) begin
        prod = {16'd0, cfg_max_power} * period;
        quo = (cfg_ramp_ms == 0) ? '1 : prod / cfg_ramp_ms;
        step = quo[15:0];
        if (target_power > present_power) begin
          up = {1'b0, present_power} + {1'b0, step};
          present_power = (up >= {1'b0, target_power}) ? target_power : up[15:0];
        end else if (step >= present_power || present_power - step <= target_power) begin
          present_power = target_power;
        end else begin
          present_power = present_power - step;
        end
        pwm = power_to_pwm(present_power);
        if (pwm != last_pwm) begin
          last_pwm = pwm;
          res.written = 1'b1;
        end
      end
      if (period != 0) last_tick = now;
    end
    res.pwm = last_pwm;
    res.power = present_power;
    return res;
  endfunction

  task automatic send_item(input logic kind, input logic [15:0] req, input logic [31:0] now);
    s_tuser <= kind;
    s_tdata <= {now, req};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_pwm_q.push_back(advance_setpoint(kind, req, now));
    n_sent++;
  endtask

  task automatic send_tick(input logic [31:0] now);
    send_item(KIND_TICK, 16'($urandom), now);
    clock_ms = now;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_pwm_q.size() != 0) @(posedge clk);
  endtask

  task automatic drive_reg(input logic [CfgIndexW-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_MAX_POWER:     cfg_max_power = data[15:0];
      CFG_MIN_POWER:     cfg_min_power = data[15:0];
      CFG_MAX_PWM:       cfg_max_pwm = data[15:0];
      CFG_MIN_PWM:       cfg_min_pwm = data[15:0];
      CFG_RAMP_DURATION: cfg_ramp_ms = data;
      default: ;
    endcase
  endtask

  // registers only change once the block has delivered everything
  task automatic apply_settings(input logic [15:0] max_p, input logic [15:0] min_p,
                                input logic [15:0] max_w, input logic [15:0] min_w,
                                input logic [31:0] ramp_ms);
    wait_drained();
    drive_reg(CFG_MAX_POWER, {16'd0, max_p});
    drive_reg(CFG_MIN_POWER, {16'd0, min_p});
    drive_reg(CFG_MAX_PWM, {16'd0, max_w});
    drive_reg(CFG_MIN_PWM, {16'd0, min_w});
    drive_reg(CFG_RAMP_DURATION, ramp_ms);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic test_directed_defaults();
    send_item(KIND_SET_SPEED, 16'd0, 32'd0);       // same as target, nothing moves
    send_item(KIND_SET_SPEED, 16'hFFFF, 32'd0);    // clamped to max_power
    send_tick(32'd0);                              // zero period
    send_tick(32'd100);
    send_tick(32'd5100);                           // full-scale step reaches target
    send_item(KIND_SET_SPEED, 16'd300, 32'hFFFF_FFFF);
    send_tick(32'hFFFF_FFFF);                      // huge period, product wraps
    send_item(KIND_SET_SPEED, 16'd900, 32'd0);
    send_tick(32'd2);                              // time wraps past zero
  endtask

  task automatic test_directed_extremes();
    // zero ramp duration: step is all ones, up and down to the target at once
    apply_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 32'd0);
    send_item(KIND_SET_SPEED, 16'hFFFF, 32'd0);
    send_tick(32'd10);
    send_item(KIND_SET_SPEED, 16'd0, 32'd0);
    send_tick(32'd11);
    // crossed clamps, lower clamp wins
    apply_settings(16'd100, 16'd9000, 16'd777, 16'd12, 32'd30);
    send_item(KIND_SET_SPEED, 16'd50, 32'd0);
    send_tick(32'd1000);
    send_item(KIND_SET_SPEED, 16'hFFFF, 32'd0);
    // equal power span maps to min_pwm
    apply_settings(16'd500, 16'd500, 16'd3000, 16'd100, 32'd250);
    send_item(KIND_SET_SPEED, 16'd1000, 32'd0);
    send_tick(32'd2000);
    send_tick(32'd2000);
    // falling pwm span, negative products
    apply_settings(16'd40000, 16'd1000, 16'd200, 16'd60000, 32'd100000);
    send_item(KIND_SET_SPEED, 16'd40000, 32'd0);
    send_tick(32'd7000);
    send_tick(32'd107000);
  endtask

  task automatic test_input_backpressure();
    // receiver holds off while items keep coming, input must stall
    rx_hold_req = 300;
    send_item(KIND_SET_SPEED, 16'd100, 32'd0);
    for (int i = 0; i < 11; i++) send_tick(clock_ms + 32'd50);
    wait_drained();
  endtask

  task automatic random_item();
    int sel;
    logic [15:0] req;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    if ($urandom_range(0, 99) < 18) begin
      sel = $urandom_range(0, 19);
      if (sel < 9) req = 16'($urandom_range(cfg_min_power, cfg_max_power));
      else if (sel < 14) req = 16'($urandom);
      else if (sel < 16) req = target_power;
      else if (sel == 16) req = 16'd0;
      else if (sel == 17) req = 16'hFFFF;
      else if (sel == 18) req = cfg_max_power;
      else req = cfg_min_power;
      send_item(KIND_SET_SPEED, req, $urandom);
    end else begin
      sel = $urandom_range(0, 39);
      if (sel == 0) send_tick($urandom);
      else if (sel == 1) send_tick(clock_ms);
      else send_tick(clock_ms + $urandom_range(1, 400));
    end
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: apply_settings(16'd1000, 16'd0, 16'd1000, 16'd0, 32'd5000);
        1: apply_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 32'd1);
        2: apply_settings(16'd40000, 16'd1000, 16'd200, 16'd60000, 32'd100000);
        3: apply_settings(16'd500, 16'd500, 16'd3000, 16'd100, 32'd250);
        4: apply_settings(16'd100, 16'd9000, 16'd777, 16'd12, 32'd30);
        5: apply_settings(16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        6: apply_settings(16'd2000, 16'd0, 16'hFFFF, 16'd0, 32'd0);
        9: apply_settings(16'd12000, 16'd200, 16'd50000, 16'd300, 32'd3000);
        default: apply_settings(16'($urandom), 16'($urandom_range(0, 4000)),
                                16'($urandom), 16'($urandom),
                                ($urandom_range(0, 3) == 0) ? $urandom
                                                            : $urandom_range(1, 20000));
      endcase
      // one stretch in the middle and the tail run without any idling
      tx_idle_on = (p != 3 && p != 9);
      rx_idle_on = (p != 3 && p != 9);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) random_item();
    end
  endtask

  // result sink: checks transfers and models receiver stalls
  initial begin
    int stall_left;
    pwm_result_t want;
    pwm_result_t got;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got = '{written: m_tuser, pwm: m_tdata[15:0], power: m_tdata[31:16]};
        if (expected_pwm_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result at %0t: written %0b pwm %0d power %0d",
                     $realtime, got.written, got.pwm, got.power);
        end else begin
          want = expected_pwm_q.pop_front();
          n_checked++;
          if (want.written) n_updates++;
          if (got !== want) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch at %0t: expected written %0b pwm %0d power %0d, got %0b %0d %0d",
                       $realtime, want.written, want.pwm, want.power,
                       got.written, got.pwm, got.power);
          end
        end
      end
      if (rx_hold_req > 0) begin
        stall_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 18);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_pwm_q.size());
        $display("tb_ramped_pwm_setpoint_generator_core failed");
        $finish;
      end
    end
  end

  initial begin
    cfg_max_power = MAX_POWER_RESET;
    cfg_min_power = MIN_POWER_RESET;
    cfg_max_pwm = MAX_PWM_RESET;
    cfg_min_pwm = MIN_PWM_RESET;
    cfg_ramp_ms = RAMP_DURATION_RESET;
    target_power = '0;
    present_power = '0;
    last_pwm = '0;
    last_tick = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_defaults();
    test_directed_extremes();
    test_input_backpressure();
    test_random_phases();

    wait_drained();
    repeat (100) @(posedge clk);

    $display("covered %0d items over %0d register settings; %0d results checked, %0d pwm updates",
             n_sent, n_settings, n_checked, n_updates);
    if (err_count == 0 && expected_pwm_q.size() == 0) begin
      $display("tb_ramped_pwm_setpoint_generator_core passed");
    end else begin
      $display("%0d errors, %0d results outstanding", err_count, expected_pwm_q.size());
      $display("tb_ramped_pwm_setpoint_generator_core failed");
    end
    $finish;
  end

endmodule
